// File: sv/rgi_pkg.sv
// Shared widths and register indexes for the RGB gradient interpolator.
// No dependencies; imported by rgi_step_div and rgb_gradient_interpolator.
`timescale 1ns / 1ps

package rgi_pkg;

    // Field widths.
    localparam int CH_W   = 8;
    localparam int POS_W  = 16;
    localparam int STEP_W = 16;
    localparam int CFG_W  = 16;

    // Magnitude of (end - start) * 128 fits in 15 bits, so the divider works out 15 quotient bits.
    localparam int QUO_W  = 15;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_START_RED   = 3'd0,
        REG_START_GREEN = 3'd1,
        REG_START_BLUE  = 3'd2,
        REG_END_RED     = 3'd3,
        REG_END_GREEN   = 3'd4,
        REG_END_BLUE    = 3'd5,
        REG_START_POS   = 3'd6,
        REG_END_POS     = 3'd7
    } t_reg_idx;

endpackage

// File: sv/rgi_step_div.sv
// Per-channel step calculator: signed restoring division, one quotient bit a cycle.
// Depends on rgi_pkg.
`timescale 1ns / 1ps

module rgi_step_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic signed [rgi_pkg::STEP_W-1:0] i_dist,
    input  logic [rgi_pkg::POS_W-1:0]    i_span,
    output logic                         o_busy,
    output logic [rgi_pkg::STEP_W-1:0]   o_step
);
    import rgi_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic [QUO_W-1:0]   r_num;
    logic [POS_W-1:0]   r_rem;
    logic [POS_W-1:0]   r_den;
    logic               r_neg;
    logic [CNT_W-1:0]   r_cnt;

    logic [POS_W:0]     w_trial;
    logic               w_fits;
    logic [POS_W-1:0]   w_den_mag;
    logic [QUO_W-1:0]   w_dist_mag;
    logic [STEP_W-1:0]  w_quo;

    // Operand magnitudes; a zero span divides by one.
    always_comb begin
        w_dist_mag = i_dist[STEP_W-1] ? QUO_W'(-i_dist) : QUO_W'(i_dist);
        if (i_span == '0) begin
            w_den_mag = POS_W'(1);
        end else if (i_span[POS_W-1]) begin
            w_den_mag = -i_span;
        end else begin
            w_den_mag = i_span;
        end
    end

    // One restoring step: bring down the next dividend bit and try the subtraction.
    assign w_trial = {r_rem, r_num[QUO_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_num <= '0;
            r_neg <= 1'b0;
        end else if (i_go) begin
            r_cnt <= CNT_W'(QUO_W);
            r_num <= w_dist_mag;
            r_neg <= i_dist[STEP_W-1] ^ (i_span[POS_W-1]);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_num <= {r_num[QUO_W-2:0], w_fits};
        end
    end

    // Remainder and divisor are payload.
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_den <= w_den_mag;
        end else if (r_cnt != '0) begin
            r_rem <= w_fits ? POS_W'(w_trial - {1'b0, r_den}) : POS_W'(w_trial);
        end
    end

    // Once finished r_num holds the quotient magnitude; apply the sign and double.
    assign w_quo  = r_neg ? -{1'b0, r_num} : {1'b0, r_num};
    assign o_step = {w_quo[STEP_W-2:0], 1'b0};
    assign o_busy = (r_cnt != '0);

endmodule

// File: sv/rgb_gradient_interpolator.sv
// Top level of the RGB gradient interpolator: configuration, step dividers and pipeline.
// Depends on rgi_pkg and rgi_step_div.
`timescale 1ns / 1ps

// o_valid rises once an accepted position has passed the stage-one, stage-two and output registers.
// Throughput: one position per cycle while busy is low.
// A configuration write holds busy high from its own cycle until the three step dividers,
// one quotient bit a cycle, have recomputed the per-channel steps.
// Reset (synchronous, active low) clears the configuration and the valid bits; steps read as zero.
// Results cannot be stalled: each colour is shown for exactly one cycle.
module rgb_gradient_interpolator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [rgi_pkg::POS_W-1:0]    i_position,
    output logic                         o_valid,
    output logic [rgi_pkg::CH_W-1:0]     o_red,
    output logic [rgi_pkg::CH_W-1:0]     o_green,
    output logic [rgi_pkg::CH_W-1:0]     o_blue,
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_addr,
    input  logic [rgi_pkg::CFG_W-1:0]    i_cfg_data
);
    import rgi_pkg::*;

    // Configuration registers.
    logic [CH_W-1:0]   r_start_col [3];
    logic [CH_W-1:0]   r_end_col   [3];
    logic [POS_W-1:0]  r_start_pos;
    logic [POS_W-1:0]  r_end_pos;
    logic              r_recalc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_col <= '{default: '0};
            r_end_col   <= '{default: '0};
            r_start_pos <= '0;
            r_end_pos   <= '0;
            r_recalc    <= 1'b0;
        end else begin
            r_recalc <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (t_reg_idx'(i_cfg_addr))
                    REG_START_RED:   r_start_col[0] <= i_cfg_data[CH_W-1:0];
                    REG_START_GREEN: r_start_col[1] <= i_cfg_data[CH_W-1:0];
                    REG_START_BLUE:  r_start_col[2] <= i_cfg_data[CH_W-1:0];
                    REG_END_RED:     r_end_col[0]   <= i_cfg_data[CH_W-1:0];
                    REG_END_GREEN:   r_end_col[1]   <= i_cfg_data[CH_W-1:0];
                    REG_END_BLUE:    r_end_col[2]   <= i_cfg_data[CH_W-1:0];
                    REG_START_POS:   r_start_pos    <= i_cfg_data[POS_W-1:0];
                    REG_END_POS:     r_end_pos      <= i_cfg_data[POS_W-1:0];
                    default:         r_end_pos      <= r_end_pos;
                endcase
            end
        end
    end

    // Step dividers, one per channel, restarted after every configuration write.
    logic [POS_W-1:0]  w_span;
    logic [2:0]        w_div_busy;
    logic [STEP_W-1:0] w_step [3];
    logic              w_accept;

    assign w_span = r_end_pos - r_start_pos;

    for (genvar g = 0; g < 3; g++) begin : g_div
        logic signed [CH_W:0]       w_diff;
        logic signed [STEP_W-1:0]   w_dist;

        // (end - start) * 128 as a 16-bit signed value.
        assign w_diff = $signed({1'b0, r_end_col[g]}) - $signed({1'b0, r_start_col[g]});
        assign w_dist = {w_diff, 7'b0};

        rgi_step_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_go    (r_recalc),
            .i_dist  (w_dist),
            .i_span  (w_span),
            .o_busy  (w_div_busy[g]),
            .o_step  (w_step[g])
        );
    end

    assign busy     = i_cfg_we | r_recalc | (|w_div_busy);
    assign w_accept = start & ~busy;

    // Stage one: offset of the position from the gradient start.
    logic              r_s1_valid;
    logic [POS_W-1:0]  r_s1_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_delta <= i_position - r_start_pos;
        end
    end

    // Stage two: step times offset, kept to 16 bits.
    logic              r_s2_valid;
    logic [STEP_W-1:0] r_s2_prod [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_s2_prod[c] <= STEP_W'(w_step[c] * r_s1_delta);
        end
    end

    // Stage three: add the start colour in 8.8 form and keep the integer part.
    logic              r_out_valid;
    logic [CH_W-1:0]   r_out_col [3];
    logic [STEP_W-1:0] w_acc [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_acc[c] = {r_start_col[c], 8'b0} + r_s2_prod[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_out_col[c] <= w_acc[c][STEP_W-1:STEP_W-CH_W];
        end
    end

    assign o_valid = r_out_valid;
    assign o_red   = r_out_col[0];
    assign o_green = r_out_col[1];
    assign o_blue  = r_out_col[2];

    // Every accepted request produces its colour through the stage-one, stage-two and output registers.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##3 o_valid)
        else $error("accepted request did not produce a result after three cycles");

    // A configuration write, once registered in r_recalc, starts all three dividers.
    a_recalc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_recalc |=> (&w_div_busy))
        else $error("step dividers did not start after a configuration write");

    // Dividers run only while the pipeline is empty, so no item sees a stale step.
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_div_busy) |-> !(r_s1_valid || r_s2_valid || w_accept))
        else $error("request in flight while steps are being recomputed");

endmodule
